[hdl/plu_pkg.sv]
// Phong lighting unit: shared types, widths, stage counts and register codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package plu_pkg;

  localparam int VEC_W      = 16;          // input vector component width
  localparam int COL_W      = 8;           // colour channel width
  localparam int RAW_W      = 18;          // signed component before normalising
  localparam int UNIT_W     = 16;          // signed Q1.14 unit component
  localparam int PWR_W      = 15;          // unsigned Q1.14 in [0, 1.0]
  localparam int RGB_W      = 3 * COL_W;
  localparam int SIDE_W     = 64;          // data carried alongside a normaliser
  localparam int SQ_STAGES  = 31;          // one root bit per stage
  localparam int DIV_STAGES = 15;          // one quotient bit per stage
  localparam int PWR_STAGES = 255;         // one exponent step per stage
  localparam int SHIN_W     = 8;
  localparam int IN_W       = 9 * VEC_W;

  localparam logic [PWR_W-1:0] UNIT = PWR_W'(16384);

  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic [PWR_W-1:0]         pwr_t;
  typedef logic [SIDE_W-1:0]        side_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic [RGB_W-1:0]         rgb_t;

  // configuration register indexes
  localparam logic [2:0] REG_AMB_LIGHT = 3'd0;
  localparam logic [2:0] REG_DIF_LIGHT = 3'd1;
  localparam logic [2:0] REG_SPE_LIGHT = 3'd2;
  localparam logic [2:0] REG_AMB_MAT   = 3'd3;
  localparam logic [2:0] REG_DIF_MAT   = 3'd4;
  localparam logic [2:0] REG_SPE_MAT   = 3'd5;
  localparam logic [2:0] REG_SHININESS = 3'd6;
  localparam logic [2:0] REG_LIGHT_MODE = 3'd7;

  // round a Q2.28 sum to Q1.14, ties away from zero, clamp to +-1.0
  function automatic unit_t dot_round(input logic signed [33:0] s);
    logic [33:0] mag;
    logic [20:0] q;
    logic [UNIT_W-1:0] res;
    mag = s[33] ? 34'(-s) : 34'(s);
    q   = 21'((mag + 34'd8192) >> 14);
    if (q > 21'(UNIT)) q = 21'(UNIT);
    res = {1'b0, q[PWR_W-1:0]};
    return s[33] ? unit_t'(-res) : unit_t'(res);
  endfunction

endpackage

[hdl/plu_norm.sv]
// Vector normaliser: squares, digit-by-digit square root, restoring divide.
// Depends on plu_pkg. One vector per cycle while en_i is high.
`timescale 1ns / 1ps

module plu_norm import plu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  raw_t  vec_i [3],
  input  side_t side_i,
  output logic  valid_o,
  output unit_t unit_o [3],
  output side_t side_o
);

  // squares
  logic        vla_q;
  logic [34:0] sq_q [3];
  raw_t        va_q [3];
  side_t       sda_q;

  // square root pipeline, index 0 loaded from the sum
  logic [SQ_STAGES:0] vls_q;
  logic [61:0]        rem_q  [SQ_STAGES+1];
  logic [61:0]        root_q [SQ_STAGES+1];
  raw_t               vs_q   [SQ_STAGES+1][3];
  logic               zs_q   [SQ_STAGES+1];
  side_t              sds_q  [SQ_STAGES+1];

  // divide pipeline, index 0 loaded from the root
  logic [DIV_STAGES:0] vld_q;
  logic [45:0]         dr_q  [DIV_STAGES+1][3];
  logic [PWR_W-1:0]    quo_q [DIV_STAGES+1][3];
  logic                sg_q  [DIV_STAGES+1][3];
  logic [30:0]         dq_q  [DIV_STAGES+1];
  logic                zd_q  [DIV_STAGES+1];
  side_t               sdd_q [DIV_STAGES+1];

  logic  vlo_q;
  unit_t un_q [3];
  side_t sdo_q;

  logic [36:0] sum;
  assign sum = 37'(sq_q[0]) + 37'(sq_q[1]) + 37'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vla_q <= 1'b0;
      vls_q <= '0;
      vld_q <= '0;
      vlo_q <= 1'b0;
    end else if (en_i) begin
      vla_q <= valid_i;
      vls_q <= {vls_q[SQ_STAGES-1:0], vla_q};
      vld_q <= {vld_q[DIV_STAGES-1:0], vls_q[SQ_STAGES]};
      vlo_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 35'(vec_i[i]) * 35'(vec_i[i]);
        va_q[i] <= vec_i[i];
        vs_q[0][i] <= va_q[i];
      end
      sda_q     <= side_i;
      rem_q[0]  <= {sum[33:0], 28'b0};
      root_q[0] <= '0;
      zs_q[0]   <= (sum == '0);
      sds_q[0]  <= sda_q;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam logic [61:0] BitVal = 62'(1) << (60 - 2 * k);
    logic [61:0] trial;
    logic        ge;
    assign trial = root_q[k] + BitVal;
    assign ge    = (rem_q[k] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - trial : rem_q[k];
        root_q[k+1] <= ge ? (root_q[k] >> 1) + BitVal : root_q[k] >> 1;
        vs_q[k+1]   <= vs_q[k];
        zs_q[k+1]   <= zs_q[k];
        sds_q[k+1]  <= sds_q[k];
      end
    end
  end

  // numerator |v| * 2^28 plus half the divisor for rounding
  logic [30:0] root;
  assign root = root_q[SQ_STAGES][30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i]  <= {(vs_q[SQ_STAGES][i][RAW_W-1] ? RAW_W'(-vs_q[SQ_STAGES][i])
                                                     : RAW_W'(vs_q[SQ_STAGES][i])), 28'b0}
                       + 46'(root >> 1);
        quo_q[0][i] <= '0;
        sg_q[0][i]  <= vs_q[SQ_STAGES][i][RAW_W-1];
      end
      dq_q[0]  <= root;
      zd_q[0]  <= zs_q[SQ_STAGES];
      sdd_q[0] <= sds_q[SQ_STAGES];
    end
  end

  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    localparam int Sh = DIV_STAGES - 1 - d;
    logic [45:0] sub;
    assign sub = 46'(dq_q[d]) << Sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 0; i < 3; i++) begin
          if (dr_q[d][i] >= sub) begin
            dr_q[d+1][i]  <= dr_q[d][i] - sub;
            quo_q[d+1][i] <= quo_q[d][i] | (PWR_W'(1) << Sh);
          end else begin
            dr_q[d+1][i]  <= dr_q[d][i];
            quo_q[d+1][i] <= quo_q[d][i];
          end
          sg_q[d+1][i] <= sg_q[d][i];
        end
        dq_q[d+1]  <= dq_q[d];
        zd_q[d+1]  <= zd_q[d];
        sdd_q[d+1] <= sdd_q[d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        logic [PWR_W-1:0] q;
        q = (quo_q[DIV_STAGES][i] > UNIT) ? UNIT : quo_q[DIV_STAGES][i];
        if (zd_q[DIV_STAGES]) un_q[i] <= '0;
        else if (sg_q[DIV_STAGES][i]) un_q[i] <= unit_t'(-{1'b0, q});
        else un_q[i] <= unit_t'({1'b0, q});
      end
      sdo_q <= sdd_q[DIV_STAGES];
    end
  end

  assign valid_o = vlo_q;
  assign unit_o  = un_q;
  assign side_o  = sdo_q;

endmodule

[hdl/plu_power.sv]
// Specular power: raises |dot(R,V)| to the shininess, one exponent step per stage.
// Depends on plu_pkg.
`timescale 1ns / 1ps

module plu_power import plu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pwr_t              cos_i,
  input  unit_t             dnl_i,
  input  logic [SHIN_W-1:0] shin_i,
  output logic              valid_o,
  output pwr_t              pwr_o,
  output unit_t             dnl_o
);

  logic [PWR_STAGES:0] vl_q;
  pwr_t  p_q [PWR_STAGES+1];
  pwr_t  c_q [PWR_STAGES+1];
  unit_t d_q [PWR_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[PWR_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= UNIT;
      c_q[0] <= cos_i;
      d_q[0] <= dnl_i;
    end
  end

  for (genvar k = 0; k < PWR_STAGES; k++) begin : g_step
    logic [2*PWR_W-1:0] prod;
    logic               act;
    assign prod = p_q[k] * c_q[k];
    assign act  = (SHIN_W'(k) < shin_i) && (p_q[k] != '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k+1] <= act ? PWR_W'((prod + 30'd8192) >> 14) : p_q[k];
        c_q[k+1] <= c_q[k];
        d_q[k+1] <= d_q[k];
      end
    end
  end

  assign valid_o = vl_q[PWR_STAGES];
  assign pwr_o   = p_q[PWR_STAGES];
  assign dnl_o   = d_q[PWR_STAGES];

endmodule

[hdl/plu_mix.sv]
// Colour mix: ambient, diffuse and specular terms per channel, clamp and scale.
// Depends on plu_pkg.
`timescale 1ns / 1ps

module plu_mix import plu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  unit_t dnl_i,
  input  pwr_t  pwr_i,
  input  rgb_t  amb_light_i,
  input  rgb_t  dif_light_i,
  input  rgb_t  spe_light_i,
  input  rgb_t  amb_mat_i,
  input  rgb_t  dif_mat_i,
  input  rgb_t  spe_mat_i,
  output logic  valid_o,
  output col_t  rgb_o [3]
);

  logic [3:0] vl_q;

  logic [15:0] a_q [3];
  logic [15:0] d_q [3];
  logic [15:0] s_q [3];
  unit_t       dnl_q;
  pwr_t        p_q;

  logic [29:0]        amb_q [3];
  logic signed [31:0] dif_q [3];
  logic [30:0]        spe_q [3];

  logic signed [33:0] sum_q [3];
  col_t               out_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        // channel 0 is red, held in the top byte
        a_q[c] <= amb_light_i[(2-c)*COL_W +: COL_W] * amb_mat_i[(2-c)*COL_W +: COL_W];
        d_q[c] <= dif_light_i[(2-c)*COL_W +: COL_W] * dif_mat_i[(2-c)*COL_W +: COL_W];
        s_q[c] <= spe_light_i[(2-c)*COL_W +: COL_W] * spe_mat_i[(2-c)*COL_W +: COL_W];

        amb_q[c] <= {a_q[c], 14'b0};
        dif_q[c] <= 32'($signed({1'b0, d_q[c]})) * 32'(dnl_q);
        spe_q[c] <= s_q[c] * p_q;

        sum_q[c] <= $signed({4'b0, amb_q[c]}) + 34'(dif_q[c]) + $signed({3'b0, spe_q[c]});
      end
      dnl_q <= dnl_i;
      p_q   <= pwr_i;
    end
  end

  // divide by 255 * 16384 with rounding: shift out 2^14, then divide by 255
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        logic [33:0] t;
        logic [19:0] u;
        logic [19:0] q;
        t = 34'(sum_q[c]) + 34'd2088960;
        u = 20'(t >> 14);
        q = 20'((u + (u >> 8) + 20'd1) >> 8);
        if (sum_q[c] <= 0) out_q[c] <= '0;
        else if (u >= 20'd65280) out_q[c] <= '1;
        else out_q[c] <= q[COL_W-1:0];
      end
    end
  end

  assign valid_o = vl_q[3];
  assign rgb_o   = out_q;

endmodule

[hdl/phong_lighting_unit.sv]
// Phong lighting unit top level: configuration registers, dot products,
// reflection and output queue. Depends on plu_pkg, plu_norm, plu_power, plu_mix.
`timescale 1ns / 1ps

// Per-pixel Phong shader, one fragment per transfer.
// Input stream s_axis_*: nine signed Q1.14 components (normal, light direction,
// view). Output stream m_axis_*: red, green and blue, 8 bits each.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// clock edge; write only while no fragment is in flight.
// Throughput: one fragment per cycle while the output queue is not full. The
// path from the input transfer to m_axis_tvalid runs through a chain of two
// normalisers (one square-root bit and one quotient bit per stage) and the
// 255-stage specular exponent line.
// The whole pipeline advances as one; a two-entry output queue lets it keep
// running while one result waits. When the receiver stalls and the queue
// fills, the pipeline holds and s_axis_tready drops; nothing is lost.
// Reset (rst_ni low, asynchronous) empties the pipeline and queue, clears the
// colour registers and light mode, and sets shininess to 2.

module phong_lighting_unit import plu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // normal_x, normal_y, normal_z, light_dir_x, light_dir_y, light_dir_z,
  // view_x, view_y, view_z (16 bits each)
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // red_out, green_out, blue_out (8 bits each)
  output logic [RGB_W-1:0] m_axis_tdata,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [RGB_W-1:0] cfg_wdata_i
);

  // configuration registers
  rgb_t              amb_l_q, dif_l_q, spe_l_q, amb_m_q, dif_m_q, spe_m_q;
  logic [SHIN_W-1:0] shin_q;
  logic              mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_l_q <= '0;
      dif_l_q <= '0;
      spe_l_q <= '0;
      amb_m_q <= '0;
      dif_m_q <= '0;
      spe_m_q <= '0;
      shin_q  <= SHIN_W'(2);
      mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AMB_LIGHT:  amb_l_q <= cfg_wdata_i;
        REG_DIF_LIGHT:  dif_l_q <= cfg_wdata_i;
        REG_SPE_LIGHT:  spe_l_q <= cfg_wdata_i;
        REG_AMB_MAT:    amb_m_q <= cfg_wdata_i;
        REG_DIF_MAT:    dif_m_q <= cfg_wdata_i;
        REG_SPE_MAT:    spe_m_q <= cfg_wdata_i;
        REG_SHININESS:  shin_q  <= cfg_wdata_i[SHIN_W-1:0];
        REG_LIGHT_MODE: mode_q  <= cfg_wdata_i[0];
      endcase
    end
  end

  // pipeline enable: advance unless the output queue is full
  logic [1:0] cnt_q;
  logic       en;
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // unpack and widen the input components
  raw_t n_raw [3];
  raw_t l_raw [3];
  raw_t v_raw [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_raw[i] = RAW_W'($signed(s_axis_tdata[i*VEC_W +: VEC_W]));
      l_raw[i] = mode_q ? RAW_W'(UNIT) : RAW_W'($signed(s_axis_tdata[(3+i)*VEC_W +: VEC_W]));
      v_raw[i] = RAW_W'($signed(s_axis_tdata[(6+i)*VEC_W +: VEC_W]));
    end
  end

  logic  n_vld, l_vld, v_vld;
  unit_t n_u [3];
  unit_t l_u [3];
  unit_t v_u [3];

  plu_norm u_norm_n (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .vec_i(n_raw),
    .side_i('0), .valid_o(n_vld), .unit_o(n_u), .side_o()
  );
  plu_norm u_norm_l (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .vec_i(l_raw),
    .side_i('0), .valid_o(l_vld), .unit_o(l_u), .side_o()
  );
  plu_norm u_norm_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .vec_i(v_raw),
    .side_i('0), .valid_o(v_vld), .unit_o(v_u), .side_o()
  );

  // dot(N,L) in two stages, then the reflection in two stages
  logic [3:0]          vl_q;
  logic signed [31:0]  pnl_q [3];
  unit_t               n1_q [3], l1_q [3], v1_q [3];
  unit_t               n2_q [3], l2_q [3], v2_q [3], dnl2_q;
  logic signed [31:0]  pdn_q [3];
  unit_t               l3_q [3], v3_q [3], dnl3_q;
  raw_t                rr_q [3];
  side_t               side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en) begin
      vl_q <= {vl_q[2:0], n_vld & l_vld & v_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pnl_q[i] <= n_u[i] * l_u[i];
        n1_q[i]  <= n_u[i];
        l1_q[i]  <= l_u[i];
        v1_q[i]  <= v_u[i];
        n2_q[i]  <= n1_q[i];
        l2_q[i]  <= l1_q[i];
        v2_q[i]  <= v1_q[i];
        pdn_q[i] <= dnl2_q * n2_q[i];
        l3_q[i]  <= l2_q[i];
        v3_q[i]  <= v2_q[i];
      end
      dnl2_q  <= dot_round(34'(pnl_q[0]) + 34'(pnl_q[1]) + 34'(pnl_q[2]));
      dnl3_q  <= dnl2_q;
      side4_q <= {dnl3_q, v3_q[2], v3_q[1], v3_q[0]};
    end
  end

  // R = -L + round(2 * dot(N,L) * N / 1.0)
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] mag;
        logic [16:0] h;
        mag = pdn_q[i][31] ? 32'(-pdn_q[i]) : 32'(pdn_q[i]);
        h   = 17'((mag + 32'd4096) >> 13);
        rr_q[i] <= pdn_q[i][31] ? -RAW_W'(l3_q[i]) - RAW_W'(h)
                                : -RAW_W'(l3_q[i]) + RAW_W'(h);
      end
    end
  end

  logic  r_vld;
  unit_t r_u [3];
  side_t r_side;

  plu_norm u_norm_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vl_q[3]), .vec_i(rr_q),
    .side_i(side4_q), .valid_o(r_vld), .unit_o(r_u), .side_o(r_side)
  );

  // |dot(R,V)| in two stages
  logic [1:0]         cv_q;
  logic signed [31:0] prv_q [3];
  unit_t              dnlc_q, dnld_q;
  pwr_t               cos_q;
  unit_t              vr [3];
  unit_t              rdot;

  always_comb begin
    for (int i = 0; i < 3; i++) vr[i] = unit_t'(r_side[i*UNIT_W +: UNIT_W]);
    rdot = dot_round(34'(prv_q[0]) + 34'(prv_q[1]) + 34'(prv_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (en) begin
      cv_q <= {cv_q[0], r_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) prv_q[i] <= r_u[i] * vr[i];
      dnlc_q <= unit_t'(r_side[3*UNIT_W +: UNIT_W]);
      dnld_q <= dnlc_q;
      cos_q  <= rdot[UNIT_W-1] ? PWR_W'(-rdot) : PWR_W'(rdot);
    end
  end

  logic  p_vld;
  pwr_t  p_val;
  unit_t p_dnl;

  plu_power u_power (
    .clk_i, .rst_ni, .en_i(en), .valid_i(cv_q[1]), .cos_i(cos_q), .dnl_i(dnld_q),
    .shin_i(shin_q), .valid_o(p_vld), .pwr_o(p_val), .dnl_o(p_dnl)
  );

  logic mx_vld;
  col_t mx_rgb [3];

  plu_mix u_mix (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_vld), .dnl_i(p_dnl), .pwr_i(p_val),
    .amb_light_i(amb_l_q), .dif_light_i(dif_l_q), .spe_light_i(spe_l_q),
    .amb_mat_i(amb_m_q), .dif_mat_i(dif_m_q), .spe_mat_i(spe_m_q),
    .valid_o(mx_vld), .rgb_o(mx_rgb)
  );

  // two-entry output queue
  rgb_t fifo_q [2];
  logic wr_q, rd_q;
  logic push, pop;

  assign push          = mx_vld & en;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tdata  = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= {mx_rgb[2], mx_rgb[1], mx_rgb[0]};
  end

endmodule

[test/phong_lighting_unit_tb.sv]
// Testbench for phong_lighting_unit: directed and random fragments under several
// lighting set-ups, with back-pressure, checked against a fixed-point shading predictor.
// Depends on plu_pkg and the phong_lighting_unit RTL.
`timescale 1ns / 1ps

module phong_lighting_unit_tb;
  import plu_pkg::*;

  localparam longint ONE_Q14   = 16384;
  localparam int     IDLE_LIMIT = 4000;

  typedef struct packed {
    logic signed [VEC_W-1:0] vz, vy, vx, lz, ly, lx, nz, ny, nx;
  } frag_t;
  typedef struct packed {
    col_t blue, green, red;
  } pix_t;
  typedef longint vec3_t [3];

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RGB_W-1:0] m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_idx_i = '0;
  logic [RGB_W-1:0] cfg_wdata_i = '0;

  logic [RGB_W-1:0] shade_regs [8];
  pix_t             pending_pix [$];
  int               err_cnt = 0;
  int               rx_hold = 0;
  int               rx_hold_req = 0;
  bit               rx_free = 1'b0;
  int               idle_cycles = 0;

  phong_lighting_unit DUT (.*);

  always #4 clk_i = ~clk_i;

  // ---------------- shading predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_q14(longint v);
    if (v > ONE_Q14) return ONE_Q14;
    if (v < -ONE_Q14) return -ONE_Q14;
    return v;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    vec3_t n;
    longint unsigned s, q;
    s = 0;
    for (int i = 0; i < 3; i++) s += longint'(v[i] * v[i]);
    if (s == 0) begin
      n = '{0, 0, 0};
      return n;
    end
    q = int_sqrt(s << 28);
    for (int i = 0; i < 3; i++) n[i] = clamp_q14(round_div(v[i] * (longint'(1) << 28), q));
    return n;
  endfunction

  function automatic longint dot_q14(vec3_t a, vec3_t b);
    return clamp_q14(round_div(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], ONE_Q14));
  endfunction

  function automatic pix_t shade_fragment(frag_t f);
    vec3_t nv, lv, vv, rv;
    longint dnl, cosrv, pw, amb, dif, spe, s;
    longint unsigned den, o;
    int sh;
    pix_t px;
    logic [COL_W-1:0] ch [3];
    nv = unit_vec('{longint'(f.nx), longint'(f.ny), longint'(f.nz)});
    if (shade_regs[REG_LIGHT_MODE][0]) lv = unit_vec('{ONE_Q14, ONE_Q14, ONE_Q14});
    else lv = unit_vec('{longint'(f.lx), longint'(f.ly), longint'(f.lz)});
    vv = unit_vec('{longint'(f.vx), longint'(f.vy), longint'(f.vz)});
    dnl = dot_q14(nv, lv);
    for (int i = 0; i < 3; i++) rv[i] = -lv[i] + round_div(2 * dnl * nv[i], ONE_Q14);
    rv = unit_vec(rv);
    cosrv = dot_q14(rv, vv);
    if (cosrv < 0) cosrv = -cosrv;
    pw = ONE_Q14;
    sh = shade_regs[REG_SHININESS][7:0];
    for (int k = 0; k < sh && pw != 0; k++) pw = round_div(pw * cosrv, ONE_Q14);
    den = 255 * ONE_Q14;
    // channel 0 is red, held in the top byte of each colour register
    for (int c = 0; c < 3; c++) begin
      amb = longint'(shade_regs[REG_AMB_LIGHT][(2-c)*8 +: 8])
          * longint'(shade_regs[REG_AMB_MAT][(2-c)*8 +: 8]) * ONE_Q14;
      dif = longint'(shade_regs[REG_DIF_LIGHT][(2-c)*8 +: 8])
          * longint'(shade_regs[REG_DIF_MAT][(2-c)*8 +: 8]) * dnl;
      spe = longint'(shade_regs[REG_SPE_LIGHT][(2-c)*8 +: 8])
          * longint'(shade_regs[REG_SPE_MAT][(2-c)*8 +: 8]) * pw;
      s = amb + dif + spe;
      o = 0;
      if (s > 0) begin
        o = (longint'(s) + den / 2) / den;
        if (o > 255) o = 255;
      end
      ch[c] = o[7:0];
    end
    px.red = ch[0];
    px.green = ch[1];
    px.blue = ch[2];
    return px;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(logic [2:0] idx, logic [RGB_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx < REG_SHININESS) shade_regs[idx] = val;
    else if (idx == REG_SHININESS) shade_regs[idx] = {16'd0, val[7:0]};
    else shade_regs[idx] = {23'd0, val[0]};
  endtask

  task automatic send_frag(frag_t f, int gap);
    @(negedge clk_i);
    s_axis_tdata = f;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pix.push_back(shade_fragment(f));
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // drop the offer first so the last fragment is not taken again
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [VEC_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return VEC_W'($urandom);                               // full range
    if (r < 4) return '0;
    return VEC_W'($signed($urandom_range(0, 32767)) - 16384);         // typical magnitude
  endfunction

  function automatic frag_t rand_frag();
    frag_t f;
    f = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
         rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    // occasionally zero one whole vector
    case ($urandom_range(0, 19))
      0: {f.nx, f.ny, f.nz} = '0;
      1: {f.lx, f.ly, f.lz} = '0;
      2: {f.vx, f.vy, f.vz} = '0;
      default: ;
    endcase
    return f;
  endfunction

  task automatic random_setup(int mode);
    for (int i = 0; i < 6; i++) write_reg(i[2:0], RGB_W'($urandom));
    write_reg(REG_SHININESS, RGB_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 40)));
    write_reg(REG_LIGHT_MODE, RGB_W'((mode < 0) ? $urandom_range(0, 1) : mode));
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_frag(rand_frag(), pick_gap());
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    frag_t f;
    wait_drained();
    write_reg(REG_AMB_LIGHT, 24'h402010);
    write_reg(REG_DIF_LIGHT, 24'hFFFFFF);
    write_reg(REG_SPE_LIGHT, 24'hFF8000);
    write_reg(REG_AMB_MAT, 24'hFF80FF);
    write_reg(REG_DIF_MAT, 24'hC0C0C0);
    write_reg(REG_SPE_MAT, 24'hFFFFFF);
    write_reg(REG_SHININESS, 8'd0);
    write_reg(REG_LIGHT_MODE, 1'b0);
    send_frag('0, 0);                                        // all vectors zero
    f = '0; f.nz = 16384; f.lz = 16384; f.vz = 16384;
    send_frag(f, 0);                                         // zero angle, shininess zero
    f = '0; f.nz = 16384; f.lx = 16384; f.vy = 16384;
    send_frag(f, 1);                                         // shininess zero with zero cosine
    f = '0; f.nz = 16384; f.lz = -16384; f.vz = 16384;
    send_frag(f, 0);                                         // light behind: negative diffuse
    f = '0; f.lx = 1000; f.ly = -2000; f.vx = 3;
    send_frag(f, 0);                                         // zero normal
    f = {9{16'sh8000}};
    send_frag(f, 2);                                         // most negative everywhere
    f = {9{16'sh7FFF}};
    send_frag(f, 0);
    f = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
         16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
    send_frag(f, 0);
    f = '0; f.nx = 1; f.ly = -1; f.vz = 1;                   // tiny vectors
    send_frag(f, 0);
    wait_drained();
    write_reg(REG_SHININESS, 8'd255);
    write_reg(REG_LIGHT_MODE, 1'b1);
    f = '0; f.nx = 5; f.ny = 5; f.nz = 5; f.vx = 7; f.vy = 7; f.vz = 7;
    send_frag(f, 0);                                         // parallel light along normal
    f = {9{16'sh7FFF}}; f.lx = 0; f.ly = 0; f.lz = 0;
    send_frag(f, 0);                                         // parallel ignores input light
    f = '0; f.nz = -16384; f.vx = 100;
    send_frag(f, 3);
    wait_drained();
    write_reg(REG_LIGHT_MODE, 1'b0);
    f = '0; f.nx = 16384; f.lx = 16384; f.vx = 16384;
    send_frag(f, 0);                                         // full specular, shininess 255
    wait_drained();
    for (int i = 0; i < 6; i++) write_reg(i[2:0], 24'hFFFFFF);
    write_reg(REG_SHININESS, 8'd1);
    send_frag(f, 0);                                         // saturating sum
    f = '0; f.nx = 16384; f.lx = -16384; f.vx = -16384;
    send_frag(f, 0);
    send_frag('0, 0);
    wait_drained();
    for (int i = 0; i < 6; i++) write_reg(i[2:0], 24'h000000);
    send_frag(f, 0);                                         // all colours zero
  endtask

  task automatic test_point_light();
    wait_drained();
    random_setup(0);
    send_random(300);
    wait_drained();
    random_setup(0);
    rx_free = 1'b1;                                          // stretch without receiver stalls
    send_random(200);
    rx_free = 1'b0;
  endtask

  task automatic test_parallel_light();
    wait_drained();
    random_setup(1);
    send_random(300);
  endtask

  task automatic test_backpressure();
    wait_drained();
    random_setup(-1);
    rx_hold_req = 800;                                       // long hold-off fills the pipeline
    for (int i = 0; i < 500; i++) send_frag(rand_frag(), 0);
  endtask

  task automatic test_sender_pause();
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      random_setup(-1);
      send_random(60);
      wait_drained();                                        // pause until every pixel is back
      send_random(60);
    end
  endtask

  // ---------------- receiver and checking ----------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        rx_hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (rx_free) begin
        m_axis_tready = 1'b1;
      end else begin
        int r;
        r = $urandom_range(0, 99);
        m_axis_tready = (r < 70);
        if (r >= 70 && r < 97) rx_hold = $urandom_range(0, 3);
        else if (r >= 97) rx_hold = $urandom_range(15, 60);
      end
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pix_t got, want;
      got = m_axis_tdata;
      if (pending_pix.size() == 0) begin
        report_mismatch("unexpected pixel", got, 0);
      end else begin
        want = pending_pix.pop_front();
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
      end
    end
  end

  // idle watchdog: count cycles without any transfer on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("phong_lighting_unit test failed");
      $finish;
    end
  end

  initial begin
    shade_regs = '{default: '0};
    shade_regs[REG_SHININESS] = 24'd2;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_point_light();
    test_parallel_light();
    test_backpressure();
    test_sender_pause();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("phong_lighting_unit test passed");
    end else begin
      $display("phong_lighting_unit test failed");
    end
    $finish;
  end

endmodule
